// ----- design/mkslp_pkg.sv -----
// shared types and constants for the multi-key short/long press scanner
// no dependencies

package mkslp_pkg;

	localparam int NUM_KEYS    = 10;
	localparam int REPEAT_KEYS = 4;
	localparam int PIN_BITS    = 10;
	localparam int KEY_W       = 4;
	localparam int CNT_W       = 16;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CNT_W-1:0] SHORT_RST  = CNT_W'(2);
	localparam logic [CNT_W-1:0] LONG_RST   = CNT_W'(100);
	localparam logic [CNT_W-1:0] REPEAT_RST = CNT_W'(20);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SHORT  = 2'd0,
		CFG_LONG   = 2'd1,
		CFG_REPEAT = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0] short_press_ticks;
		logic [CNT_W-1:0] long_press_ticks;
		logic [CNT_W-1:0] repeat_ticks;
	} cfg_t;

	typedef struct packed {
		logic [KEY_W-1:0] key_number;
		logic             is_long;
	} event_t;

endpackage

// ----- design/multi_key_short_long_press_scanner.sv -----
// top level of the multi-key short/long press scanner
// a word passes the input register, then the result register, as which the shared key state updates
// throughput: one word per cycle while out_ready does not stall the result register
// reset: arst_n clears key state, counters and valid flags and loads register defaults
// depends on mkslp_pkg, mkslp_cfg_regs, mkslp_scan

module multi_key_short_long_press_scanner (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [mkslp_pkg::PIN_BITS-1:0]  pin_levels,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [mkslp_pkg::KEY_W-1:0]     key_number,
	output logic                            is_long,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mkslp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mkslp_pkg::CNT_W-1:0]     cfg_data
);
	import mkslp_pkg::*;

	cfg_t                cfg;
	event_t              ev;
	logic [PIN_BITS-1:0] pin_s1;
	logic                valid_s1;
	logic                valid_s2;
	event_t              ev_s2;
	logic                adv;

	assign adv       = !valid_s2 || out_ready;
	assign in_ready  = !valid_s1 || adv;
	assign out_valid = valid_s2;
	assign key_number = ev_s2.key_number;
	assign is_long    = ev_s2.is_long;

	mkslp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mkslp_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv && valid_s1),
		.pins   (pin_s1),
		.cfg    (cfg),
		.ev     (ev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pin_s1 <= pin_levels;
		end
		if (adv && valid_s1) begin
			ev_s2 <= ev;
		end
	end

endmodule

// ----- design/mkslp_cfg_regs.sv -----
// configuration registers of the press scanner
// depends on mkslp_pkg

module mkslp_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mkslp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mkslp_pkg::CNT_W-1:0]     cfg_data,
	output mkslp_pkg::cfg_t                 cfg
);
	import mkslp_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_press_ticks <= SHORT_RST;
			cfg_q.long_press_ticks  <= LONG_RST;
			cfg_q.repeat_ticks      <= REPEAT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SHORT:  cfg_q.short_press_ticks <= cfg_data;
				CFG_LONG:   cfg_q.long_press_ticks  <= cfg_data;
				CFG_REPEAT: cfg_q.repeat_ticks      <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ----- design/mkslp_scan.sv -----
// key state and per-tick event logic of the press scanner
// depends on mkslp_pkg

module mkslp_scan (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic [mkslp_pkg::PIN_BITS-1:0] pins,
	input  mkslp_pkg::cfg_t                cfg,
	output mkslp_pkg::event_t              ev
);
	import mkslp_pkg::*;

	logic [NUM_KEYS-1:0] held_q;
	logic [CNT_W-1:0]    hold_q;
	logic [CNT_W-1:0]    repeat_q;

	logic [NUM_KEYS-1:0] pressed;
	logic [CNT_W-1:0]    hold_at [NUM_KEYS];
	logic [CNT_W-1:0]    repeat_nxt;
	event_t              ev_c;

	always_comb begin
		for (int k = 0; k < NUM_KEYS; k++) begin
			pressed[k] = (k < PIN_BITS) ? ~pins[k] : 1'b0;
		end
	end

	// hold count after each key: pressed keys since the last new press
	always_comb begin
		logic [KEY_W-1:0] cnt;
		logic             seen;
		cnt  = '0;
		seen = 1'b0;
		for (int k = 0; k < NUM_KEYS; k++) begin
			if (pressed[k] && !held_q[k]) begin
				cnt  = '0;
				seen = 1'b1;
			end
			if (pressed[k]) begin
				cnt = cnt + KEY_W'(1);
			end
			hold_at[k] = seen ? CNT_W'(cnt) : hold_q + CNT_W'(cnt);
		end
	end

	always_comb begin
		logic [CNT_W-1:0] r;
		r    = repeat_q;
		ev_c = '0;
		for (int k = 0; k < NUM_KEYS; k++) begin
			if (pressed[k]) begin
				if (k < REPEAT_KEYS) begin
					if (!held_q[k]) begin
						r = '0;
					end
					if (hold_at[k] >= cfg.long_press_ticks) begin
						r = r + CNT_W'(1);
						if (r == cfg.repeat_ticks) begin
							r                 = '0;
							ev_c.key_number   = KEY_W'(k + 1);
							ev_c.is_long      = 1'b1;
						end else begin
							ev_c = '0;
						end
					end
				end
			end else if (held_q[k] && (hold_at[k] > cfg.short_press_ticks)) begin
				ev_c.key_number = KEY_W'(k + 1);
				ev_c.is_long    = 1'b0;
			end
		end
		repeat_nxt = r;
	end

	assign ev = ev_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= '0;
			hold_q   <= '0;
			repeat_q <= '0;
		end else if (en) begin
			held_q   <= pressed;
			hold_q   <= hold_at[NUM_KEYS-1];
			repeat_q <= repeat_nxt;
		end
	end

endmodule

// ----- bench/tb_top.sv -----
// testbench for multi_key_short_long_press_scanner: directed table, then random key sequences
// checked word by word against an in-bench predictor, then an all-keys hold at zero long and repeat thresholds
// depends on mkslp_pkg and the scanner rtl

module tb_top;
	import mkslp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int DIR_ROWS = 25;
	localparam int SEG_COUNT = 8;
	localparam int SEG_WORDS = 72;
	localparam int SOAK_TICKS = 48;

	typedef struct {
		logic [PIN_BITS-1:0] pins;
		bit                  typed;
		event_t              want;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [PIN_BITS-1:0]  pin_levels = '1;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [KEY_W-1:0]     key_number;
	logic                 is_long;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CNT_W-1:0]     cfg_data = '0;

	// predictor state
	cfg_t                 scan_cfg;
	logic [NUM_KEYS-1:0]  key_down;
	logic [CNT_W-1:0]     hold_cnt;
	logic [CNT_W-1:0]     rep_cnt;

	event_t               pending_events[$];
	bit                   cur_typed = 1'b0;
	event_t               cur_want = '0;
	int                   src_idle_pct = 28;
	int                   sink_idle_pct = 81;
	int                   error_count = 0;
	int                   stall_cycles = 0;
	int                   words_in = 0;
	int                   key_events = 0;
	int                   long_events = 0;
	int                   reg_writes = 0;

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{10'h3FF, 1'b1, '{4'd0, 1'b0}},
		'{10'h1FF, 1'b1, '{4'd0, 1'b0}},
		'{10'h1FF, 1'b1, '{4'd0, 1'b0}},
		'{10'h1FF, 1'b1, '{4'd0, 1'b0}},
		'{10'h3FF, 1'b1, '{4'd10, 1'b0}},
		'{10'h000, 1'b1, '{4'd0, 1'b0}},
		'{10'h000, 1'b0, '{4'd0, 1'b0}},
		'{10'h000, 1'b0, '{4'd0, 1'b0}},
		'{10'h000, 1'b0, '{4'd0, 1'b0}},
		'{10'h000, 1'b0, '{4'd0, 1'b0}},
		'{10'h000, 1'b0, '{4'd0, 1'b0}},
		'{10'h000, 1'b0, '{4'd0, 1'b0}},
		'{10'h000, 1'b0, '{4'd0, 1'b0}},
		'{10'h000, 1'b0, '{4'd0, 1'b0}},
		'{10'h000, 1'b0, '{4'd0, 1'b0}},
		'{10'h000, 1'b0, '{4'd0, 1'b0}},
		'{10'h000, 1'b0, '{4'd0, 1'b0}},
		'{10'h000, 1'b0, '{4'd0, 1'b0}},
		'{10'h000, 1'b0, '{4'd0, 1'b0}},
		'{10'h000, 1'b0, '{4'd0, 1'b0}},
		'{10'h000, 1'b0, '{4'd0, 1'b0}},
		'{10'h3DF, 1'b0, '{4'd0, 1'b0}},
		'{10'h000, 1'b0, '{4'd0, 1'b0}},
		'{10'h3FA, 1'b0, '{4'd0, 1'b0}},
		'{10'h3FF, 1'b0, '{4'd0, 1'b0}}
	};

	multi_key_short_long_press_scanner i_dut (.*);

	always #1 clk = ~clk;

	function automatic event_t scan_tick(input logic [PIN_BITS-1:0] pins);
		event_t ev;
		bit     pressed;
		ev = '0;
		for (int k = 0; k < NUM_KEYS; k++) begin
			pressed = (k < PIN_BITS) ? !pins[k] : 1'b0;
			if (pressed) begin
				if (!key_down[k]) begin
					key_down[k] = 1'b1;
					hold_cnt = '0;
					if (k < REPEAT_KEYS)
						rep_cnt = '0;
				end
				hold_cnt = hold_cnt + CNT_W'(1);
				if (k < REPEAT_KEYS && hold_cnt >= scan_cfg.long_press_ticks) begin
					rep_cnt = rep_cnt + CNT_W'(1);
					if (rep_cnt == scan_cfg.repeat_ticks) begin
						rep_cnt = '0;
						ev.key_number = KEY_W'(k + 1);
						ev.is_long = 1'b1;
					end else begin
						// long phase without a fire wipes earlier keys' events
						ev = '0;
					end
				end
			end else if (key_down[k]) begin
				if (hold_cnt > scan_cfg.short_press_ticks) begin
					ev.key_number = KEY_W'(k + 1);
					ev.is_long = 1'b0;
				end
				key_down[k] = 1'b0;
			end
		end
		return ev;
	endfunction

	function automatic logic [PIN_BITS-1:0] next_pins(input logic [PIN_BITS-1:0] cur);
		int pick;
		pick = $urandom_range(99);
		if (pick < 72) begin
			if ($urandom_range(9) < 4)
				cur[$urandom_range(PIN_BITS-1)] = ~cur[$urandom_range(PIN_BITS-1)];
		end else if (pick < 86) begin
			cur = PIN_BITS'($urandom_range(1023));
		end else if (pick < 93) begin
			cur = '1;
		end else begin
			cur = '0;
		end
		return cur;
	endfunction

	task automatic flag_error(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	task automatic send_word(input logic [PIN_BITS-1:0] pins);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pin_levels <= pins;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// sender holds off until the scanner has drained
	task automatic settle();
		in_valid <= 1'b0;
		cur_typed <= 1'b0;
		while (pending_events.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_SHORT:  scan_cfg.short_press_ticks = val;
			CFG_LONG:   scan_cfg.long_press_ticks = val;
			CFG_REPEAT: scan_cfg.repeat_ticks = val;
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= sink_idle_pct);

	always @(posedge clk) begin
		event_t want;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (out_valid && out_ready) begin
				if (pending_events.size() == 0) begin
					flag_error($sformatf("result word key %0d long %0d with nothing expected",
						key_number, is_long));
				end else begin
					want = pending_events.pop_front();
					if (key_number !== want.key_number)
						flag_error($sformatf("key_number %0d, expected %0d",
							key_number, want.key_number));
					if (is_long !== want.is_long)
						flag_error($sformatf("is_long %0d, expected %0d (key %0d)",
							is_long, want.is_long, want.key_number));
				end
				if (key_number != 0) begin
					key_events++;
					if (is_long)
						long_events++;
				end
			end
			if (in_valid && in_ready) begin
				want = scan_tick(pin_levels);
				pending_events.push_back(cur_typed ? cur_want : want);
				words_in++;
			end
		end
	end

	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("stalled for %0d cycles with %0d results outstanding",
			stall_cycles, pending_events.size());
		$display("tb_top failed");
		$finish;
	end

	initial begin
		logic [PIN_BITS-1:0] keys;
		int                  seg;
		int                  n;
		scan_cfg = '{short_press_ticks: SHORT_RST, long_press_ticks: LONG_RST,
			repeat_ticks: REPEAT_RST};
		key_down = '0;
		hold_cnt = '0;
		rep_cnt = '0;
		keys = '1;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset defaults: quick release, long hold of all keys, overlaps
		for (n = 0; n < DIR_ROWS; n++) begin
			cur_typed <= dir_rows[n].typed;
			cur_want <= dir_rows[n].want;
			send_word(dir_rows[n].pins);
		end

		for (seg = 0; seg < SEG_COUNT; seg++) begin
			settle();
			src_idle_pct = (seg < 3) ? 28 : (seg < 6) ? 81 : 0;
			sink_idle_pct = (seg < 3) ? 81 : (seg < 6) ? 28 : 0;
			case (seg)
				1: begin
					write_reg(CFG_SHORT, '0);
					write_reg(CFG_LONG, '0);
					write_reg(CFG_REPEAT, CNT_W'(1));
				end
				4: begin
					write_reg(CFG_REPEAT, '1);
					write_reg(CFG_LONG, '1);
					write_reg(CFG_SHORT, '1);
				end
				default: begin
					write_reg(CFG_SHORT, CNT_W'($urandom_range(6)));
					write_reg(CFG_LONG, CNT_W'($urandom_range(15)));
					write_reg(CFG_REPEAT, CNT_W'($urandom_range(6, 1)));
				end
			endcase
			write_reg(CFG_SPARE, CNT_W'($urandom));
			for (n = 0; n < SEG_WORDS; n++) begin
				keys = next_pins(keys);
				send_word(keys);
			end
		end

		// all keys held with zero long and repeat thresholds, late keys released now and then
		settle();
		write_reg(CFG_SHORT, CNT_W'($urandom_range(3)));
		write_reg(CFG_LONG, '0);
		write_reg(CFG_REPEAT, '0);
		for (n = 0; n < SOAK_TICKS; n++) begin
			keys = '0;
			if (n >= SOAK_TICKS / 2 && $urandom_range(39) == 0)
				keys[$urandom_range(NUM_KEYS-1, REPEAT_KEYS)] = 1'b1;
			send_word(keys);
		end
		send_word('1);

		settle();
		repeat (4) @(negedge clk);
		if (pending_events.size() != 0)
			flag_error($sformatf("%0d results never arrived", pending_events.size()));
		$display("%0d scan words over %0d register writes and a zero-threshold hold",
			words_in, reg_writes);
		$display("%0d key events seen, %0d of them long repeats, %0d errors",
			key_events, long_events, error_count);
		if (error_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
